// File: rtl/qpp_pkg.sv
package qpp_pkg;

  // Field and datapath widths
  localparam int POS_W      = 32;
  localparam int TIME_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int DRIVE_W    = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ERR_W      = POS_W + 1;       // exact target - position
  localparam int ACC_W      = POS_W + 2;       // integrator sum before clamping
  localparam int MUL_B_W    = POS_W + 2;       // wide operand of the shared multiplier
  localparam int PROD_W     = GAIN_W + MUL_B_W;
  localparam int SUM_W      = PROD_W;          // P + I + D before saturation
  localparam int FRAC_W     = 16;              // fraction bits of the Q32.16 derivative
  localparam int QUOT_W     = POS_W + FRAC_W;  // derivative width
  localparam int DPROD_W    = 64;              // deriv_gain * derivative
  localparam int DSPLIT     = QUOT_W / 2;      // derivative split for two partial products
  localparam int DIV_STEPS  = QUOT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Command codes
  localparam logic CMD_ENC  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Phase codes {phase_b, phase_a} in Gray order
  localparam logic [1:0] PH_00 = 2'b00;
  localparam logic [1:0] PH_01 = 2'b01;
  localparam logic [1:0] PH_11 = 2'b11;
  localparam logic [1:0] PH_10 = 2'b10;

  // Gray distance codes
  localparam logic [1:0] DIST_FWD = 2'd1;
  localparam logic [1:0] DIST_BWD = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_UPPER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LOWER = 3'd4;

  // Register reset values
  localparam logic signed [GAIN_W-1:0] GAIN_ONE = 16'sd256;

  // Drive saturation bounds in the sum width
  localparam logic signed [SUM_W-1:0] DRIVE_MAX =
    {{(SUM_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] DRIVE_MIN =
    {{(SUM_W-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};

  // Encoder step decided by the front end
  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  typedef struct packed {
    logic                     cmd;
    logic                     phase_a;
    logic                     phase_b;
    logic signed [POS_W-1:0]  target_pos;
    logic [TIME_W-1:0]        timestamp;
  } in_item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      drive_valid;
    logic signed [POS_W-1:0]   position;
    logic                      direction;
    logic                      zero_interval;
  } out_item_t;

  // Classified operation passed from front to back
  typedef struct packed {
    logic                    is_tick;
    step_t                   step;
    logic signed [POS_W-1:0] target_pos;
    logic [TIME_W-1:0]       timestamp;
  } op_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic signed [GAIN_W-1:0] deriv_gain;
    logic signed [POS_W-1:0]  integ_upper;
    logic signed [POS_W-1:0]  integ_lower;
  } cfg_t;

  // Place of a phase code in the Gray sequence
  function automatic logic [1:0] gray_rank(input logic [1:0] ph);
    logic [1:0] rank;
    unique case (ph)
      PH_00: rank = 2'd0;
      PH_01: rank = 2'd1;
      PH_11: rank = 2'd2;
      PH_10: rank = 2'd3;
      default: rank = 2'd0;
    endcase
    return rank;
  endfunction

endpackage

// File: rtl/qpp_front.sv
module qpp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qpp_pkg::in_item_t in_data,
  input  logic              q_ready,
  output logic              q_push,
  output qpp_pkg::op_t      q_op
);

  logic [1:0]      last_phase_r, last_phase_nxt;
  logic [1:0]      phase;
  logic [1:0]      rank_step;
  logic            accept;
  qpp_pkg::step_t  step;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign q_push   = accept;

  // Gray distance from the last phase seen
  assign phase     = {in_data.phase_b, in_data.phase_a};
  assign rank_step = qpp_pkg::gray_rank(phase) - qpp_pkg::gray_rank(last_phase_r);

  always_comb begin
    step = qpp_pkg::STEP_NONE;
    if (in_data.cmd == qpp_pkg::CMD_ENC) begin
      if (rank_step == qpp_pkg::DIST_FWD) begin
        step = qpp_pkg::STEP_UP;
      end else if (rank_step == qpp_pkg::DIST_BWD) begin
        step = qpp_pkg::STEP_DOWN;
      end
    end
  end

  always_comb begin
    q_op.is_tick    = (in_data.cmd == qpp_pkg::CMD_TICK);
    q_op.step       = step;
    q_op.target_pos = in_data.target_pos;
    q_op.timestamp  = in_data.timestamp;
  end

  // Every accepted encoder beat records its phase, legal or not
  always_comb begin
    last_phase_nxt = last_phase_r;
    if (accept && (in_data.cmd == qpp_pkg::CMD_ENC)) begin
      last_phase_nxt = phase;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_phase_r <= qpp_pkg::PH_00;
    end else begin
      last_phase_r <= last_phase_nxt;
    end
  end

endmodule

// File: rtl/qpp_queue.sv
module qpp_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  qpp_pkg::op_t push_op,
  output logic         wr_ready,
  output logic         rd_valid,
  output qpp_pkg::op_t rd_op,
  input  logic         pop
);

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  qpp_pkg::op_t     entry_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign wr_ready = (cnt_r != CNT_W'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_op    = entry_r[rd_ptr_r];
  assign do_push  = push && wr_ready;
  assign do_pop   = pop && rd_valid;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// File: rtl/qpp_div.sv
module qpp_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [qpp_pkg::QUOT_W-1:0]   dividend,
  input  logic [qpp_pkg::TIME_W-1:0]          divisor,
  output logic                                done,
  output logic signed [qpp_pkg::QUOT_W-1:0]   quot
);

  localparam int NW = qpp_pkg::QUOT_W;
  localparam int DW = qpp_pkg::TIME_W;
  localparam int CW = qpp_pkg::DIV_CNT_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic          neg_r, neg_nxt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, num_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign fits    = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      neg_nxt  = dividend[NW-1];
      num_nxt  = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], fits};
      rem_nxt = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(qpp_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // Quotient truncates toward zero: sign applied to the magnitude
  assign done = done_r;
  assign quot = neg_r ? $signed(-num_r) : $signed(num_r);

endmodule

// File: rtl/qpp_back.sv
module qpp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  qpp_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  qpp_pkg::op_t       q_op,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output qpp_pkg::out_item_t out_data
);

  localparam int PW  = qpp_pkg::POS_W;
  localparam int EW  = qpp_pkg::ERR_W;
  localparam int AW  = qpp_pkg::ACC_W;
  localparam int BW  = qpp_pkg::MUL_B_W;
  localparam int MW  = qpp_pkg::PROD_W;
  localparam int SW  = qpp_pkg::SUM_W;
  localparam int QW  = qpp_pkg::QUOT_W;
  localparam int DPW = qpp_pkg::DPROD_W;
  localparam int FW  = qpp_pkg::FRAC_W;
  localparam int DS  = qpp_pkg::DSPLIT;
  localparam int DRW = qpp_pkg::DRIVE_W;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CLAMP = 11'b000_0000_0010,
    S_MULP  = 11'b000_0000_0100,
    S_MULI  = 11'b000_0000_1000,
    S_ACCI  = 11'b000_0001_0000,
    S_DIV   = 11'b000_0010_0000,
    S_MULDL = 11'b000_0100_0000,
    S_MULDH = 11'b000_1000_0000,
    S_DADD  = 11'b001_0000_0000,
    S_DSUM  = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Architectural state
  logic signed [PW-1:0] pos_r, pos_nxt;
  logic                 dir_r, dir_nxt;
  logic signed [PW-1:0] integ_r, integ_nxt;
  logic signed [PW-1:0] prior_pos_r, prior_pos_nxt;
  logic [PW-1:0]        prior_time_r, prior_time_nxt;

  // Per-tick working registers
  logic signed [EW-1:0]  err_r, err_nxt;
  logic signed [PW-1:0]  dpos_r, dpos_nxt;
  logic [PW-1:0]         dt_r, dt_nxt;
  logic                  zero_r, zero_nxt;
  logic signed [QW-1:0]  quot_r, quot_nxt;
  logic signed [MW-1:0]  prod_r;
  logic signed [SW-1:0]  sum_r, sum_nxt;
  logic signed [DPW-1:0] dacc_r, dacc_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  qpp_pkg::out_item_t out_data_r, out_data_nxt;

  logic                        out_free;
  logic                        pop;
  logic                        div_start;
  logic                        div_done;
  logic signed [QW-1:0]        div_quot;
  logic signed [AW-1:0]        acc_sum;
  logic signed [AW-1:0]        acc_up;
  logic signed [AW-1:0]        acc_lo;
  logic signed [AW-1:0]        acc_clamped;
  logic signed [qpp_pkg::GAIN_W-1:0] mul_a;
  logic signed [BW-1:0]        mul_b;
  logic signed [MW-1:0]        mul_p;
  logic signed [DPW-1:0]       prod_ext;
  logic signed [SW-1:0]        sat;

  assign out_free  = !out_valid_r || out_ready;
  assign pop       = q_valid && (state_r == S_IDLE) && out_free;
  assign q_pop     = pop;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Integrator sum, upper clamp first, then lower
  assign acc_sum = AW'(integ_r) + AW'(err_r);
  assign acc_up  = AW'(cfg.integ_upper);
  assign acc_lo  = AW'(cfg.integ_lower);
  always_comb begin
    acc_clamped = acc_sum;
    if (acc_clamped > acc_up) begin
      acc_clamped = acc_up;
    end
    if (acc_clamped < acc_lo) begin
      acc_clamped = acc_lo;
    end
  end

  // Shared gain multiplier, operands picked by state
  always_comb begin
    unique case (state_r)
      S_MULI: begin
        mul_a = cfg.integ_gain;
        mul_b = BW'(integ_r);
      end
      S_MULDL: begin
        mul_a = cfg.deriv_gain;
        mul_b = $signed({{(BW-DS){1'b0}}, quot_r[DS-1:0]});
      end
      S_MULDH: begin
        mul_a = cfg.deriv_gain;
        mul_b = BW'($signed(quot_r[QW-1:DS]));
      end
      default: begin
        mul_a = cfg.prop_gain;
        mul_b = BW'(err_r);
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = DPW'(prod_r);

  // Saturate to the drive range
  always_comb begin
    sat = sum_r;
    if (sum_r > qpp_pkg::DRIVE_MAX) begin
      sat = qpp_pkg::DRIVE_MAX;
    end else if (sum_r < qpp_pkg::DRIVE_MIN) begin
      sat = qpp_pkg::DRIVE_MIN;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    dir_nxt        = dir_r;
    integ_nxt      = integ_r;
    prior_pos_nxt  = prior_pos_r;
    prior_time_nxt = prior_time_r;
    err_nxt        = err_r;
    dpos_nxt       = dpos_r;
    dt_nxt         = dt_r;
    zero_nxt       = zero_r;
    quot_nxt       = quot_r;
    sum_nxt        = sum_r;
    dacc_nxt       = dacc_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    div_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          if (q_op.is_tick) begin
            err_nxt        = EW'(q_op.target_pos) - EW'(pos_r);
            dpos_nxt       = pos_r - prior_pos_r;
            dt_nxt         = q_op.timestamp - prior_time_r;
            zero_nxt       = (q_op.timestamp == prior_time_r);
            prior_pos_nxt  = pos_r;
            prior_time_nxt = q_op.timestamp;
            state_nxt      = S_CLAMP;
          end else begin
            // Encoder beat: update count and answer at once
            unique case (q_op.step)
              qpp_pkg::STEP_UP: begin
                pos_nxt = pos_r + 1'b1;
                dir_nxt = 1'b0;
              end
              qpp_pkg::STEP_DOWN: begin
                pos_nxt = pos_r - 1'b1;
                dir_nxt = 1'b1;
              end
              default: begin
                pos_nxt = pos_r;
                dir_nxt = dir_r;
              end
            endcase
            out_valid_nxt              = 1'b1;
            out_data_nxt.drive         = '0;
            out_data_nxt.drive_valid   = 1'b0;
            out_data_nxt.position      = pos_nxt;
            out_data_nxt.direction     = dir_nxt;
            out_data_nxt.zero_interval = 1'b0;
          end
        end
      end
      S_CLAMP: begin
        integ_nxt = acc_clamped[PW-1:0];
        div_start = !zero_r;
        state_nxt = S_MULP;
      end
      S_MULP: begin
        state_nxt = S_MULI;
      end
      S_MULI: begin
        sum_nxt   = SW'(prod_r);
        state_nxt = S_ACCI;
      end
      S_ACCI: begin
        sum_nxt   = sum_r + SW'(prod_r);
        state_nxt = zero_r ? S_FIN : S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          quot_nxt  = div_quot;
          state_nxt = S_MULDL;
        end
      end
      S_MULDL: begin
        state_nxt = S_MULDH;
      end
      S_MULDH: begin
        dacc_nxt  = prod_ext;
        state_nxt = S_DADD;
      end
      S_DADD: begin
        dacc_nxt  = dacc_r + {prod_ext[DPW-DS-1:0], {DS{1'b0}}};
        state_nxt = S_DSUM;
      end
      S_DSUM: begin
        // floor shift back to Q8.8
        sum_nxt   = sum_r + SW'($signed(dacc_r[DPW-1:FW]));
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.drive         = sat[DRW-1:0];
          out_data_nxt.drive_valid   = 1'b1;
          out_data_nxt.position      = pos_r;
          out_data_nxt.direction     = dir_r;
          out_data_nxt.zero_interval = zero_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pos_r        <= '0;
      dir_r        <= 1'b0;
      integ_r      <= '0;
      prior_pos_r  <= '0;
      prior_time_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      dir_r        <= dir_nxt;
      integ_r      <= integ_nxt;
      prior_pos_r  <= prior_pos_nxt;
      prior_time_r <= prior_time_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r      <= err_nxt;
    dpos_r     <= dpos_nxt;
    dt_r       <= dt_nxt;
    zero_r     <= zero_nxt;
    quot_r     <= quot_nxt;
    prod_r     <= mul_p;
    sum_r      <= sum_nxt;
    dacc_r     <= dacc_nxt;
    out_data_r <= out_data_nxt;
  end

  // Derivative divider: (dpos << 16) / dt
  qpp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({dpos_r, {FW{1'b0}}}),
    .divisor  (dt_r),
    .done     (div_done),
    .quot     (div_quot)
  );

endmodule

// File: rtl/quadrature_position_pid.sv
// Quadrature encoder position counter with a fixed-point PID position loop.
// Input channel (in_valid/in_ready/in_data): each beat is an encoder phase
// sample (cmd 0) or a control tick (cmd 1) carrying a target and a timestamp.
// Output channel (out_valid/out_ready/out_data): exactly one beat per input
// beat, in order; drive and zero_interval are only meaningful on ticks.
// Config port (cfg_we/cfg_idx/cfg_wdata): write-only gains and integrator
// clamps, taken on any edge with cfg_we high; write only while idle.
// An encoder sample is answered straight from the idle back end; a control
// tick spends nearly all of its time in the 48-step bit-serial divider that
// forms the derivative, skipped when the time change is zero. Encoder samples
// sustain one per cycle while the output is not stalled; a tick holds the
// back end until its result is in the output register.
// A two-entry queue between the classifying front end and the arithmetic
// back end keeps in_ready up while a tick is in progress, until it fills.
// When out_ready is low the result beat holds in the output register and
// the back end waits; the queue then absorbs up to two more input beats.
// Reset clears position, direction, integrator, prior position and time,
// sets all gains to 1.0 and both clamps to zero.
module quadrature_position_pid (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  qpp_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output qpp_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [qpp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [qpp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int GW = qpp_pkg::GAIN_W;

  qpp_pkg::cfg_t cfg_r, cfg_nxt;
  qpp_pkg::op_t  push_op;
  qpp_pkg::op_t  head_op;
  logic          q_ready;
  logic          q_push;
  logic          q_valid;
  logic          q_pop;

  // Configuration registers; unused indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        qpp_pkg::CFG_PROP_GAIN:   cfg_nxt.prop_gain   = cfg_wdata[GW-1:0];
        qpp_pkg::CFG_INTEG_GAIN:  cfg_nxt.integ_gain  = cfg_wdata[GW-1:0];
        qpp_pkg::CFG_DERIV_GAIN:  cfg_nxt.deriv_gain  = cfg_wdata[GW-1:0];
        qpp_pkg::CFG_INTEG_UPPER: cfg_nxt.integ_upper = cfg_wdata;
        qpp_pkg::CFG_INTEG_LOWER: cfg_nxt.integ_lower = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain   <= qpp_pkg::GAIN_ONE;
      cfg_r.integ_gain  <= qpp_pkg::GAIN_ONE;
      cfg_r.deriv_gain  <= qpp_pkg::GAIN_ONE;
      cfg_r.integ_upper <= '0;
      cfg_r.integ_lower <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  qpp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_op     (push_op)
  );

  qpp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_op  (push_op),
    .wr_ready (q_ready),
    .rd_valid (q_valid),
    .rd_op    (head_op),
    .pop      (q_pop)
  );

  qpp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_op      (head_op),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/qpp_checker.sv
module qpp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input qpp_pkg::out_item_t out_data
);

  // Output beat stays up while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // Stalled beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output payload changed while stalled");

  // Encoder results carry no drive and no interval flag
  a_enc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.drive_valid |->
      (out_data.drive == '0) && !out_data.zero_interval)
    else $error("encoder result with drive or interval flag");

  // Interval flag only on tick results
  a_zero_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_interval |-> out_data.drive_valid)
    else $error("interval flag on a non-tick result");

  // Reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind quadrature_position_pid qpp_checker u_qpp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/sv/quadrature_position_pid_test.sv
`timescale 1ns / 1ps

module quadrature_position_pid_test;
  import qpp_pkg::*;

  localparam logic signed [POS_W-1:0]  POS_TOP     = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0]  POS_BOTTOM  = 32'sh8000_0000;
  localparam logic signed [GAIN_W-1:0] GAIN_TOP    = 16'sh7FFF;
  localparam logic signed [GAIN_W-1:0] GAIN_BOTTOM = 16'sh8000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_BEATS  = 325;  // per traffic phase
  localparam int PRINT_CAP     = 40;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Controller mirror: settings
  logic signed [GAIN_W-1:0] kp_m = GAIN_ONE;
  logic signed [GAIN_W-1:0] ki_m = GAIN_ONE;
  logic signed [GAIN_W-1:0] kd_m = GAIN_ONE;
  logic signed [POS_W-1:0]  clamp_hi_m = '0;
  logic signed [POS_W-1:0]  clamp_lo_m = '0;

  // Controller mirror: state
  logic [1:0]               phase_m = '0;
  logic signed [POS_W-1:0]  count_m = '0;
  logic                     dir_m = 1'b0;
  logic signed [POS_W-1:0]  integ_m = '0;
  logic signed [POS_W-1:0]  prev_count_m = '0;
  logic [TIME_W-1:0]        prev_time_m = '0;

  out_item_t expected_status[$];
  out_item_t head_status;
  int        mismatch_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      walk_back = 1'b0;

  quadrature_position_pid dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // 2-bit Gray code and its rank map onto each other by the same function
  function automatic logic [1:0] gray2(input logic [1:0] v);
    return {v[1], v[1] ^ v[0]};
  endfunction

  // Advance the mirror by one input beat and return the status it should produce
  function automatic out_item_t controller_step(input in_item_t b);
    out_item_t          r;
    logic [1:0]         ph;
    logic [1:0]         rank_step;
    logic [TIME_W-1:0]  span32;
    logic signed [31:0] moved;
    longint             tgt, cur, err, acc, p_term, i_term, d_term;
    longint             span, rate, total, gain;
    r = '0;
    if (b.cmd == CMD_ENC) begin
      ph = {b.phase_b, b.phase_a};
      rank_step = gray2(ph) - gray2(phase_m);
      if (rank_step == DIST_FWD) begin
        count_m = count_m + 1;
        dir_m = 1'b0;
      end else if (rank_step == DIST_BWD) begin
        count_m = count_m - 1;
        dir_m = 1'b1;
      end
      phase_m = ph;
    end else begin
      tgt = b.target_pos;
      cur = count_m;
      err = tgt - cur;
      acc = integ_m;
      acc = acc + err;
      // upper clamp first, so crossed limits leave the lower one
      if (acc > clamp_hi_m) acc = clamp_hi_m;
      if (acc < clamp_lo_m) acc = clamp_lo_m;
      integ_m = acc[31:0];
      gain = kp_m;
      p_term = gain * err;
      gain = ki_m;
      acc = integ_m;
      i_term = gain * acc;
      d_term = 0;
      span32 = b.timestamp - prev_time_m;
      r.zero_interval = (span32 == '0);
      if (span32 != '0) begin
        moved = count_m - prev_count_m;
        span = span32;
        rate = moved;
        rate = (rate * 65536) / span;
        gain = kd_m;
        d_term = (gain * rate) >>> 16;
      end
      total = p_term + i_term + d_term;
      if (total > DRIVE_MAX) total = DRIVE_MAX;
      if (total < DRIVE_MIN) total = DRIVE_MIN;
      r.drive = total[DRIVE_W-1:0];
      r.drive_valid = 1'b1;
      prev_count_m = count_m;
      prev_time_m = b.timestamp;
    end
    r.position = count_m;
    r.direction = dir_m;
    return r;
  endfunction

  function automatic in_item_t encoder_beat(input logic [1:0] ph);
    in_item_t b;
    b.cmd = CMD_ENC;
    b.phase_b = ph[1];
    b.phase_a = ph[0];
    b.target_pos = $urandom();
    b.timestamp = $urandom();
    return b;
  endfunction

  // One Gray step from the current phase, forward or backward
  function automatic in_item_t step_beat(input logic back);
    return encoder_beat(gray2(gray2(phase_m) + (back ? DIST_BWD : DIST_FWD)));
  endfunction

  function automatic in_item_t tick_beat(input logic signed [POS_W-1:0] aim,
                                         input logic [TIME_W-1:0] stamp);
    in_item_t b;
    b.cmd = CMD_TICK;
    b.phase_a = $urandom_range(0, 1);
    b.phase_b = $urandom_range(0, 1);
    b.target_pos = aim;
    b.timestamp = stamp;
    return b;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
  endtask

  // Status beat checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("status beat with none pending", out_data.position, '0);
      end else begin
        head_status = expected_status.pop_front();
        if (out_data.drive !== head_status.drive)
          report_mismatch("drive", out_data.drive, head_status.drive);
        if (out_data.drive_valid !== head_status.drive_valid)
          report_mismatch("drive_valid", out_data.drive_valid, head_status.drive_valid);
        if (out_data.position !== head_status.position)
          report_mismatch("position", out_data.position, head_status.position);
        if (out_data.direction !== head_status.direction)
          report_mismatch("direction", out_data.direction, head_status.direction);
        if (out_data.zero_interval !== head_status.zero_interval)
          report_mismatch("zero_interval", out_data.zero_interval,
                          head_status.zero_interval);
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
  end

  // Offer one beat, hold it until taken, then record what it should produce
  task automatic send_beat(input in_item_t b);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_status.push_back(controller_step(b));
  endtask

  // Stop sending and let every pending status come out
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it after its last write
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_PROP_GAIN:   kp_m = data[GAIN_W-1:0];
      CFG_INTEG_GAIN:  ki_m = data[GAIN_W-1:0];
      CFG_DERIV_GAIN:  kd_m = data[GAIN_W-1:0];
      CFG_INTEG_UPPER: clamp_hi_m = data;
      CFG_INTEG_LOWER: clamp_lo_m = data;
      default: ;
    endcase
  endtask

  // Gains go out with junk in the upper half, which must be dropped
  task automatic load_settings(input logic [GAIN_W-1:0] kp, ki, kd,
                               input logic [POS_W-1:0] hi, lo);
    logic [31:0] junk;
    junk = $urandom();
    reg_write(CFG_PROP_GAIN, {junk[31:16], kp});
    reg_write(CFG_INTEG_GAIN, {junk[15:0], ki});
    reg_write(CFG_DERIV_GAIN, {junk[23:8], kd});
    reg_write(CFG_INTEG_UPPER, hi);
    reg_write(CFG_INTEG_LOWER, lo);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    logic [31:0] u;
    case ($urandom_range(0, 3))
      0: u = {16'd0, GAIN_TOP};
      1: u = {16'd0, GAIN_BOTTOM};
      2: u = $urandom();
      default: u = $urandom_range(0, 2048) - 1024;
    endcase
    return u[GAIN_W-1:0];
  endfunction

  // Forward and backward walks, wrap of the Gray cycle, no change, illegal jumps
  task automatic test_encoder_steps();
    send_beat(encoder_beat(PH_10));  // back across the wrap
    send_beat(encoder_beat(PH_11));
    send_beat(encoder_beat(PH_01));
    send_beat(encoder_beat(PH_00));
    send_beat(encoder_beat(PH_01));  // forward again
    send_beat(encoder_beat(PH_01));  // no change
    send_beat(encoder_beat(PH_10));  // both bits flip
    send_beat(encoder_beat(PH_11));
    send_beat(encoder_beat(PH_00));  // both bits flip
  endtask

  // Reset gains: zero interval, target extremes, timestamp wrap
  task automatic test_interval_cases();
    send_beat(tick_beat('0, '0));
    send_beat(tick_beat(POS_TOP, 32'd1));
    send_beat(tick_beat(POS_BOTTOM, 32'hFFFF_FFFF));
    send_beat(step_beat(1'b0));
    send_beat(tick_beat('0, 32'd2));
  endtask

  // Extreme gains and widest clamps push the sum past both rails
  task automatic test_drive_saturation();
    settle_idle();
    load_settings(GAIN_BOTTOM, GAIN_BOTTOM, GAIN_TOP, POS_TOP, POS_BOTTOM);
    send_beat(tick_beat(POS_TOP, prev_time_m + 1));
    send_beat(tick_beat(POS_BOTTOM, prev_time_m));
    repeat (4) send_beat(step_beat(1'b0));
    send_beat(tick_beat(POS_BOTTOM, prev_time_m + 96));
  endtask

  // Lower limit above upper limit: integrator lands on the lower one
  task automatic test_crossed_clamps();
    settle_idle();
    load_settings(GAIN_TOP, GAIN_ONE, GAIN_BOTTOM, -32'sd100, 32'sd100);
    send_beat(tick_beat('0, prev_time_m));
    send_beat(tick_beat(32'sd5000, prev_time_m + 7));
  endtask

  // Writes to indexes past the last register change nothing
  task automatic test_unused_registers();
    settle_idle();
    for (int i = CFG_INTEG_LOWER + 1; i < (1 << CFG_IDX_W); i++)
      reg_write(i[CFG_IDX_W-1:0], $urandom());
    cfg_we <= 1'b0;
    send_beat(tick_beat(32'sd12345, prev_time_m + 1));
  endtask

  // Mostly clean Gray walks with ticks near the position, some noise
  task automatic test_random_traffic();
    logic [31:0]             roll;
    logic [31:0]             pick;
    logic signed [POS_W-1:0] aim;
    logic [TIME_W-1:0]       stamp;
    logic [POS_W-1:0]        hi, lo;
    for (int phase = 0; phase < 4; phase++) begin
      settle_idle();
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hi = POS_TOP;
          lo = POS_BOTTOM;
        end
        1: begin
          send_idle_pct = 48;
          recv_stall_pct = 0;
          hi = $urandom_range(0, 1 << 20);
          lo = -$urandom_range(0, 1 << 20);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 48;
          hi = $urandom();
          lo = $urandom();
        end
        default: begin
          send_idle_pct = 35;
          recv_stall_pct = 35;
          hi = 32'sd1000;
          lo = -32'sd1000;
        end
      endcase
      load_settings(pick_gain(), pick_gain(), pick_gain(), hi, lo);
      for (int n = 0; n < RANDOM_BEATS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          if ($urandom_range(0, 99) < 15) walk_back = !walk_back;
          send_beat(step_beat(walk_back));
        end else if (roll < 62) begin
          pick = $urandom_range(0, 3);
          send_beat(encoder_beat(pick[1:0]));
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 70) aim = count_m + $urandom_range(0, 600) - 300;
          else aim = $urandom();
          pick = $urandom_range(0, 99);
          if (pick < 75) stamp = prev_time_m + $urandom_range(1, 2000);
          else if (pick < 85) stamp = prev_time_m;
          else stamp = $urandom();
          send_beat(tick_beat(aim, stamp));
        end
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_encoder_steps();
    test_interval_cases();
    test_drive_saturation();
    test_crossed_clamps();
    test_unused_registers();
    test_random_traffic();
    settle_idle();
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
